// ----- src/profile_travel_time_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for profile_travel_time
// Shared property forms, clocked on aclk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef PROFILE_TRAVEL_TIME_DEFINES_SVH
`define PROFILE_TRAVEL_TIME_DEFINES_SVH

// Same-cycle implication.
`define PTT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("profile_travel_time assertion failed");

// Next-cycle implication.
`define PTT_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("profile_travel_time assertion failed");

`endif

// ----- src/ptt_pkg.sv -----
// ----------------------------------------------------------------------------
// ptt_pkg
// Types and constants shared by the travel time block and its divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ptt_pkg;

    localparam int MAX_INTERVALS = 1024;
    localparam int IDX_W         = $clog2(MAX_INTERVALS);
    localparam int SPEED_W       = 16;
    localparam int WEEK_SECONDS  = 604800;
    localparam logic [31:0] WEEK_TICKS = 32'(WEEK_SECONDS * 256);

    // Divider geometry: widest dividend and divisor, and the step counter.
    localparam int DIV_W  = 42;
    localparam int DVSR_W = 32;
    localparam int CNT_W  = 6;

    // Register indexes on the configuration port.
    localparam logic REG_INTERVAL_SECONDS = 1'b0;
    localparam logic REG_INTERVAL_TOTAL   = 1'b1;

    // Input actions.
    localparam logic ACT_LOAD    = 1'b0;
    localparam logic ACT_COMPUTE = 1'b1;

    typedef struct packed {
        logic                start;
        logic [DIV_W-1:0]    dividend;
        logic [DVSR_W-1:0]   divisor;
        logic [CNT_W-1:0]    count;
    } div_req_t;

    typedef struct packed {
        logic                busy;
        logic                done;
        logic [DIV_W-1:0]    quotient;
        logic [DVSR_W-1:0]   remainder;
    } div_rsp_t;

    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_MODW = 11'b000_0000_0010,
        S_DIVL = 11'b000_0000_0100,
        S_MODC = 11'b000_0000_1000,
        S_RD   = 11'b000_0001_0000,
        S_SPD  = 11'b000_0010_0000,
        S_DIVS = 11'b000_0100_0000,
        S_MUL  = 11'b000_1000_0000,
        S_UPD  = 11'b001_0000_0000,
        S_FBD  = 11'b010_0000_0000,
        S_OUT  = 11'b100_0000_0000
    } state_t;

endpackage

// ----- src/ptt_ram.sv -----
// ----------------------------------------------------------------------------
// ptt_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

// ----- src/ptt_div.sv -----
// ----------------------------------------------------------------------------
// ptt_div
// Restoring divider, one quotient bit per cycle, shared by every division.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptt_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  ptt_pkg::div_req_t req,
    output ptt_pkg::div_rsp_t rsp
);
    import ptt_pkg::*;

    logic [DIV_W-1:0]  quo_reg;
    logic [DVSR_W-1:0] rem_reg;
    logic [DVSR_W-1:0] dvsr_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              done_reg;
    logic [DVSR_W:0]   shifted;
    logic [DVSR_W:0]   diff;

    // The dividend arrives left-aligned, so its top bit feeds each step.
    assign shifted = {rem_reg, quo_reg[DIV_W-1]};
    assign diff    = shifted - {1'b0, dvsr_reg};

    // Step counter and the done pulse on the last step.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= (cnt_reg == CNT_W'(1));
            if (req.start) begin
                cnt_reg <= req.count;
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    // Partial remainder and quotient shift register.
    always_ff @(posedge aclk) begin
        if (req.start) begin
            quo_reg  <= req.dividend;
            rem_reg  <= '0;
            dvsr_reg <= req.divisor;
        end else if (cnt_reg != '0) begin
            if (!diff[DVSR_W]) begin
                rem_reg <= diff[DVSR_W-1:0];
                quo_reg <= {quo_reg[DIV_W-2:0], 1'b1};
            end else begin
                rem_reg <= shifted[DVSR_W-1:0];
                quo_reg <= {quo_reg[DIV_W-2:0], 1'b0};
            end
        end
    end

    assign rsp.busy      = (cnt_reg != '0);
    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

// ----- src/profile_travel_time.sv -----
// ----------------------------------------------------------------------------
// profile_travel_time
// Edge travel time over a per-interval speed profile, or at a fallback speed.
// ----------------------------------------------------------------------------
// Usage: an input beat with s_action low writes s_slot_speed into the speed
// table at s_slot and gives no result. A beat with s_action high computes a
// travel time and gives exactly one result beat on the m_ channel
// (m_travel_time, m_error). Every table entry that a compute beat reaches
// must have been loaded before.
// Divisions run on one shared restoring divider, one bit a cycle; the week
// reduction is five compare-and-subtract steps. A fallback compute runs a
// single division, or none for a zero speed. A profile compute runs the
// week, interval and wrap reductions, then a division on each speed interval
// that the edge leaves and on the one where it ends. s_ready is low for the
// whole computation; the next beat is taken the cycle after the result is
// parked. Results wait in an output register; while the receiver stalls, a
// finished result holds in the block until that register is free, and
// s_ready stays low meanwhile. Reset (synchronous, active low) returns the
// sequencer to idle, drops m_valid and restores interval_seconds to 900 and
// interval_total to 672. The speed table is not cleared by reset.
// Configuration goes through the APB port (0x0 interval_seconds,
// 0x4 interval_total) and is to be written only while the block is idle;
// the block itself does not enforce this.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "profile_travel_time_defines.svh"

module profile_travel_time (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_action,
    input  logic [9:0]  s_slot,
    input  logic [15:0] s_slot_speed,
    input  logic [19:0] s_edge_length,
    input  logic [31:0] s_start_time,
    input  logic        s_use_profile,
    input  logic [15:0] s_fallback_speed,
    // Result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_travel_time,
    output logic        m_error
);
    import ptt_pkg::*;

    state_t state_reg, state_next;

    logic [16:0]        secs_reg;
    logic [10:0]        total_reg;
    logic [24:0]        r_reg, r_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [19:0]        rest_reg, rest_next;
    logic [32:0]        result_reg, result_next;
    logic [SPEED_W-1:0] s_reg, s_next;
    logic [40:0]        prod_reg;
    logic               first_reg, first_next;
    logic [31:0]        res_time_reg, res_time_next;
    logic               res_err_reg, res_err_next;
    logic [31:0]        t_reg, t_next;
    logic [2:0]         wk_reg, wk_next;
    logic               m_valid_reg;
    logic [31:0]        m_time_reg;
    logic               m_error_reg;

    logic [16:0]        secs_eff;
    logic [24:0]        ival;
    logic [10:0]        total_eff;
    logic [24:0]        l_minus_r;
    logic [24:0]        mul_b;
    logic [23:0]        len9;
    logic [19:0]        fb10;
    logic [35:0]        ts;
    logic [33:0]        sum;
    logic [32:0]        grown;
    logic [25:0]        step;
    logic [IDX_W:0]     idx_inc;
    logic [31:0]        wk_sub;
    logic               out_load;
    logic               cfg_wr;
    logic               ram_we;
    logic [SPEED_W-1:0] ram_rdata;
    div_req_t           div_req;
    div_rsp_t           div_rsp;

    // Effective configuration: zero acts as one, the count caps at the table.
    assign secs_eff  = (secs_reg == '0) ? 17'd1 : secs_reg;
    assign ival      = {secs_eff, 8'b0};
    assign total_eff = (total_reg == '0) ? 11'd1 :
                       (total_reg > 11'(MAX_INTERVALS)) ? 11'(MAX_INTERVALS) : total_reg;
    assign l_minus_r = ival - r_reg;
    assign mul_b     = first_reg ? l_minus_r : ival;

    // Fallback operands: len*2359296 = (len*9) << 18, divisor 10*speed.
    assign len9 = ({4'b0, s_edge_length} << 3) + {4'b0, s_edge_length};
    assign fb10 = ({4'b0, s_fallback_speed} << 3) + {3'b0, s_fallback_speed, 1'b0};

    assign ts      = div_rsp.quotient[35:0];
    assign sum     = {1'b0, result_reg} + {9'b0, ts[24:0]};
    assign grown   = result_reg + {8'b0, ival};
    assign step    = {1'b0, prod_reg[40:16]} + {25'b0, (prod_reg[15:0] != '0)};
    assign idx_inc = {1'b0, idx_reg} + (IDX_W+1)'(1);

    // One week in ticks, scaled by 16, 8, 4, 2 and 1 for the week reduction.
    assign wk_sub = WEEK_TICKS << wk_reg;

    assign s_ready  = (state_reg == S_IDLE);
    assign out_load = (state_reg == S_OUT) && (!m_valid_reg || m_ready);
    assign ram_we   = s_valid && s_ready && (s_action == ACT_LOAD);

    // Configuration registers.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            secs_reg  <= 17'd900;
            total_reg <= 11'd672;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_INTERVAL_SECONDS) begin
                secs_reg <= pwdata[16:0];
            end else begin
                total_reg <= pwdata[10:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_INTERVAL_TOTAL) begin
            prdata = {21'b0, total_reg};
        end else begin
            prdata = {15'b0, secs_reg};
        end
    end

    // Speed table.
    ptt_ram #(
        .WIDTH (SPEED_W),
        .DEPTH (MAX_INTERVALS)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (s_slot),
        .wdata (s_slot_speed),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    // Shared divider.
    ptt_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Sequencer.
    always_comb begin
        state_next    = state_reg;
        r_next        = r_reg;
        idx_next      = idx_reg;
        rest_next     = rest_reg;
        result_next   = result_reg;
        s_next        = s_reg;
        first_next    = first_reg;
        res_time_next = res_time_reg;
        res_err_next  = res_err_reg;
        t_next        = t_reg;
        wk_next       = wk_reg;
        div_req       = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid && (s_action == ACT_COMPUTE)) begin
                    rest_next  = s_edge_length;
                    first_next = 1'b1;
                    if (s_use_profile) begin
                        t_next     = s_start_time;
                        wk_next    = 3'd4;
                        state_next = S_MODW;
                    end else if (s_fallback_speed == '0) begin
                        res_time_next = '1;
                        res_err_next  = 1'b1;
                        state_next    = S_OUT;
                    end else begin
                        div_req.start    = 1'b1;
                        div_req.dividend = {len9, 18'b0};
                        div_req.divisor  = {12'b0, fb10};
                        div_req.count    = CNT_W'(42);
                        state_next       = S_FBD;
                    end
                end
            end
            S_MODW: begin
                // Time within the week by compare and subtract, then its interval.
                if (t_reg >= wk_sub) begin
                    t_next = t_reg - wk_sub;
                end
                if (wk_reg == '0) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = {t_next[27:0], 14'b0};
                    div_req.divisor  = {7'b0, ival};
                    div_req.count    = CNT_W'(28);
                    state_next       = S_DIVL;
                end else begin
                    wk_next = wk_reg - 3'd1;
                end
            end
            S_DIVL: begin
                // Keep the offset inside the interval, wrap the interval index.
                if (div_rsp.done) begin
                    r_next           = div_rsp.remainder[24:0];
                    div_req.start    = 1'b1;
                    div_req.dividend = {div_rsp.quotient[19:0], 22'b0};
                    div_req.divisor  = {21'b0, total_eff};
                    div_req.count    = CNT_W'(20);
                    state_next       = S_MODC;
                end
            end
            S_MODC: begin
                if (div_rsp.done) begin
                    idx_next   = div_rsp.remainder[IDX_W-1:0];
                    state_next = S_RD;
                end
            end
            S_RD: begin
                state_next = S_SPD;
            end
            S_SPD: begin
                // A zero speed ends the walk with an error.
                if (ram_rdata == '0) begin
                    res_time_next = '1;
                    res_err_next  = 1'b1;
                    state_next    = S_OUT;
                end else begin
                    s_next           = ram_rdata;
                    div_req.start    = 1'b1;
                    div_req.dividend = {rest_reg, 22'b0};
                    div_req.divisor  = {16'b0, ram_rdata};
                    div_req.count    = CNT_W'(36);
                    state_next       = S_DIVS;
                end
            end
            S_DIVS: begin
                if (div_rsp.done) begin
                    if (first_reg) begin
                        // First interval: finish early or spend up to its end.
                        if (ts < {11'b0, l_minus_r}) begin
                            res_time_next = ts[31:0];
                            res_err_next  = 1'b0;
                            state_next    = S_OUT;
                        end else begin
                            result_next = {8'b0, l_minus_r};
                            state_next  = S_MUL;
                        end
                    end else if (ts < {11'b0, ival}) begin
                        res_time_next = (sum[33:32] != '0) ? '1 : sum[31:0];
                        res_err_next  = (sum[33:32] != '0);
                        state_next    = S_OUT;
                    end else if (grown[32]) begin
                        res_time_next = '1;
                        res_err_next  = 1'b1;
                        state_next    = S_OUT;
                    end else begin
                        result_next = grown;
                        state_next  = S_MUL;
                    end
                end
            end
            S_MUL: begin
                state_next = S_UPD;
            end
            S_UPD: begin
                // Metres covered: truncated in the first interval, rounded up later.
                if (first_reg) begin
                    rest_next = rest_reg - prod_reg[35:16];
                end else if (step >= {6'b0, rest_reg}) begin
                    rest_next = '0;
                end else begin
                    rest_next = rest_reg - step[19:0];
                end
                first_next = 1'b0;
                if (idx_inc >= total_eff) begin
                    idx_next = '0;
                end else begin
                    idx_next = idx_inc[IDX_W-1:0];
                end
                state_next = S_RD;
            end
            S_FBD: begin
                if (div_rsp.done) begin
                    res_time_next = (div_rsp.quotient[41:32] != '0) ? '1
                                                                    : div_rsp.quotient[31:0];
                    res_err_next  = (div_rsp.quotient[41:32] != '0);
                    state_next    = S_OUT;
                end
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Working and output payload.
    always_ff @(posedge aclk) begin
        r_reg        <= r_next;
        idx_reg      <= idx_next;
        rest_reg     <= rest_next;
        result_reg   <= result_next;
        s_reg        <= s_next;
        first_reg    <= first_next;
        res_time_reg <= res_time_next;
        res_err_reg  <= res_err_next;
        t_reg        <= t_next;
        wk_reg       <= wk_next;
        prod_reg     <= s_reg * mul_b;
        if (out_load) begin
            m_time_reg  <= res_time_reg;
            m_error_reg <= res_err_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_travel_time = m_time_reg;
    assign m_error       = m_error_reg;

    // Checks on the sequencer and the result register.
    `PTT_ASSERT_IMP(a_ready_div_idle, s_ready, !div_rsp.busy)
    `PTT_ASSERT_IMP(a_out_from_park, $rose(m_valid_reg), $past(state_reg == S_OUT))
    `PTT_ASSERT_IMP(a_error_saturates, m_valid_reg && m_error_reg, m_time_reg == 32'hFFFF_FFFF)

endmodule
